### rtl/flg_pkg.sv
// Shared types, constants and register codes of the fading life grid engine.
`default_nettype none

package flg_pkg;

    // Grid geometry.
    localparam int GRID_SIDE  = 64;
    localparam int CELL_TOTAL = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W     = $clog2(CELL_TOTAL);
    localparam int COORD_W    = $clog2(GRID_SIDE);
    localparam int FEED_W     = $clog2(CELL_TOTAL + GRID_SIDE + 2);
    localparam int CHAIN_LEN  = 2 * GRID_SIDE + 3;
    localparam int COUNT_W    = 13;
    localparam int GEN_W      = 16;
    localparam int LEVEL_W    = 8;

    typedef logic [LEVEL_W-1:0] t_level;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_GEN     = 2'd2,
        CMD_CLR_GEN = 2'd3
    } t_cmd;

    // Configuration register indexes.
    localparam logic [2:0] REG_RULE_MODE   = 3'd0;
    localparam logic [2:0] REG_BIRTH       = 3'd1;
    localparam logic [2:0] REG_STEP        = 3'd2;
    localparam logic [2:0] REG_FLOOR       = 3'd3;
    localparam logic [2:0] REG_CEILING     = 3'd4;
    localparam logic [2:0] REG_NBR_THRESH  = 3'd5;
    localparam logic [2:0] REG_LIVE_THRESH = 3'd6;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        t_level     cell_value;
    } t_in_item;

    typedef struct packed {
        t_level             read_level;
        logic [COUNT_W-1:0] alive_count;
        logic [COUNT_W-1:0] change_count;
        logic [GEN_W-1:0]   generation;
    } t_out_item;

    typedef struct packed {
        logic   rule_mode;
        t_level birth_level;
        t_level level_step;
        t_level floor_level;
        t_level ceiling_level;
        t_level neighbour_threshold;
        t_level alive_threshold;
    } t_cfg;

    // Neighborhood of one cell as seen from the chain taps.
    typedef struct packed {
        t_level [7:0] nbr;
        logic   [7:0] nbr_in_grid;
        t_level       center;
    } t_window;

endpackage

`default_nettype wire

### rtl/flg_ram.sv
// Generic single-write, single-read memory with registered read data.
`default_nettype none

module flg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/flg_cell.sv
// One stage of the level chain: holds a cell level and passes it on when shifted.
`default_nettype none

module flg_cell (
    input  wire logic           i_clk,
    input  wire logic           i_shift,
    input  wire flg_pkg::t_level i_level,
    output flg_pkg::t_level      o_level
);
    import flg_pkg::*;

    t_level r_level;

    // Take the neighbor's level on every shift.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_level <= i_level;
        end
    end

    assign o_level = r_level;

endmodule

`default_nettype wire

### rtl/flg_rule.sv
// Next-level rule for one cell: neighbor count, gain, loss and rule choice.
`default_nettype none

module flg_rule (
    input  wire flg_pkg::t_cfg    i_cfg,
    input  wire flg_pkg::t_window i_win,
    output flg_pkg::t_level       o_next
);
    import flg_pkg::*;

    t_level       limit;
    logic [3:0]   nbr_cnt;
    logic [8:0]   gain_sum;
    t_level       gain;
    t_level       lose;
    logic         cnt_two_three;
    logic         cnt_three;

    // Count in-grid neighbors above the limit of the active rule.
    always_comb begin
        limit   = i_cfg.rule_mode ? '0 : i_cfg.neighbour_threshold;
        nbr_cnt = '0;
        for (int i = 0; i < 8; i++) begin
            if (i_win.nbr_in_grid[i] && (i_win.nbr[i] > limit)) begin
                nbr_cnt = nbr_cnt + 4'd1;
            end
        end
        cnt_two_three = (nbr_cnt == 4'd2) || (nbr_cnt == 4'd3);
        cnt_three     = (nbr_cnt == 4'd3);
    end

    // Saturating gain and floored loss.
    always_comb begin
        gain_sum = {1'b0, i_win.center} + {1'b0, i_cfg.level_step};
        gain     = (gain_sum > {1'b0, i_cfg.ceiling_level}) ? i_cfg.ceiling_level
                                                            : gain_sum[7:0];
        if ((i_win.center < i_cfg.level_step) ||
            ((i_win.center - i_cfg.level_step) < i_cfg.floor_level)) begin
            lose = i_cfg.floor_level;
        end else begin
            lose = i_win.center - i_cfg.level_step;
        end
    end

    // Pick the next level under the selected rule.
    always_comb begin
        if (i_cfg.rule_mode) begin
            if (i_win.center != '0) begin
                o_next = cnt_two_three ? gain : '0;
            end else begin
                o_next = cnt_three ? i_cfg.birth_level : '0;
            end
        end else begin
            if (i_win.center > i_cfg.alive_threshold) begin
                o_next = cnt_two_three ? gain : lose;
            end else begin
                o_next = cnt_three ? gain : '0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/fading_life_grid_engine.sv
// Top level of the fading life grid engine: command sequencer, grid memory and level chain.
`default_nettype none

// The engine keeps a 64 by 64 grid of 8-bit cell levels in one memory and takes
// one command at a time: a cell write, a cell read, a counter clear or a generation.
// In a generation the grid streams through the memory read port one cell per cycle
// into a chain of 2*GRID_SIDE+3 level stages, and each new level is written back in
// place once its old value has been read from the memory into the chain. After
// reset a clearing pass zeroes the grid, during which no command is taken;
// configuration writes are always taken. A finished result waits in the output
// register while the next command is already accepted.
module fading_life_grid_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire flg_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output flg_pkg::t_out_item      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data
);
    import flg_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ_WAIT,
        S_GEN,
        S_FINISH
    } t_state;

    t_state              r_state;
    t_cfg                r_cfg;
    t_in_item            r_item;
    t_out_item           r_out;
    logic                r_out_v;
    t_level              r_rd_level;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [COUNT_W-1:0]  r_alive_total;
    logic [COUNT_W-1:0]  r_changed_total;
    logic [GEN_W-1:0]    r_gen_count;
    logic [COUNT_W-1:0]  r_alive_acc;
    logic [COUNT_W-1:0]  r_changed_acc;

    // Generation pipeline: issue, chain shift, evaluate.
    logic                r_issuing;
    logic [FEED_W-1:0]   r_k;
    logic                r_p1_v;
    logic                r_p1_inb;
    logic                r_p1_ev;
    logic                r_p2_v;
    logic                r_p2_ev;
    logic [ADDR_W-1:0]   r_c;
    logic [COORD_W-1:0]  r_cx;
    logic [COORD_W-1:0]  r_cy;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    t_level              ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    t_level              ram_rdata;

    logic                item_inside;
    logic [ADDR_W-1:0]   item_addr;
    logic                eval;
    logic                eval_last;
    t_level              chain_in;
    t_level              chain_q [CHAIN_LEN];
    t_window             win;
    t_level              next_level;
    logic                up_ok;
    logic                dn_ok;
    logic                lf_ok;
    logic                rt_ok;
    logic                out_free;

    // Addressed cell of the held command.
    assign item_inside = ({3'b000, r_item.cell_x} < 9'(GRID_SIDE)) &&
                         ({3'b000, r_item.cell_y} < 9'(GRID_SIDE));
    assign item_addr   = ADDR_W'(ADDR_W'(r_item.cell_y) * ADDR_W'(GRID_SIDE)
                                 + ADDR_W'(r_item.cell_x));

    assign eval      = (r_state == S_GEN) && r_p2_v && r_p2_ev;
    assign eval_last = eval && (r_c == ADDR_W'(CELL_TOTAL - 1));
    assign out_free  = !r_out_v || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Memory port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr;
        ram_wdata = '0;
        ram_raddr = item_addr;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_EXEC: begin
                if ((r_item.cmd == CMD_WRITE) && item_inside) begin
                    ram_we    = 1'b1;
                    ram_waddr = item_addr;
                    ram_wdata = r_item.cell_value;
                end
            end
            S_GEN: begin
                ram_raddr = r_k[ADDR_W-1:0];
                if (eval) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_c;
                    ram_wdata = next_level;
                end
            end
            default: begin
            end
        endcase
    end

    flg_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (CELL_TOTAL)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Level chain: stage 0 takes the cell just read, later stages hold older cells.
    assign chain_in = r_p1_inb ? ram_rdata : '0;

    for (genvar j = 0; j < CHAIN_LEN; j++) begin : g_chain
        if (j == 0) begin : g_head
            flg_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (r_p1_v),
                .i_level (chain_in),
                .o_level (chain_q[j])
            );
        end else begin : g_body
            flg_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (r_p1_v),
                .i_level (chain_q[j-1]),
                .o_level (chain_q[j])
            );
        end
    end

    // Window around the center cell, with edge masks from its coordinates.
    assign up_ok = (r_cy != '0);
    assign dn_ok = (r_cy != COORD_W'(GRID_SIDE - 1));
    assign lf_ok = (r_cx != '0);
    assign rt_ok = (r_cx != COORD_W'(GRID_SIDE - 1));

    always_comb begin
        win.center         = chain_q[GRID_SIDE + 1];
        win.nbr[0]         = chain_q[2 * GRID_SIDE + 2];
        win.nbr[1]         = chain_q[2 * GRID_SIDE + 1];
        win.nbr[2]         = chain_q[2 * GRID_SIDE];
        win.nbr[3]         = chain_q[GRID_SIDE + 2];
        win.nbr[4]         = chain_q[GRID_SIDE];
        win.nbr[5]         = chain_q[2];
        win.nbr[6]         = chain_q[1];
        win.nbr[7]         = chain_q[0];
        win.nbr_in_grid[0] = up_ok && lf_ok;
        win.nbr_in_grid[1] = up_ok;
        win.nbr_in_grid[2] = up_ok && rt_ok;
        win.nbr_in_grid[3] = lf_ok;
        win.nbr_in_grid[4] = rt_ok;
        win.nbr_in_grid[5] = dn_ok && lf_ok;
        win.nbr_in_grid[6] = dn_ok;
        win.nbr_in_grid[7] = dn_ok && rt_ok;
    end

    flg_rule u_rule (
        .i_cfg  (r_cfg),
        .i_win  (win),
        .o_next (next_level)
    );

    // Sequencer, configuration registers, totals and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_addr      <= '0;
            r_cfg           <= '{rule_mode: 1'b0, birth_level: 8'd100, level_step: 8'd1,
                                 floor_level: 8'd10, ceiling_level: 8'd200,
                                 neighbour_threshold: 8'd60, alive_threshold: 8'd40};
            r_alive_total   <= '0;
            r_changed_total <= '0;
            r_gen_count     <= '0;
            r_out_v         <= 1'b0;
            r_issuing       <= 1'b0;
            r_p1_v          <= 1'b0;
            r_p2_v          <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_RULE_MODE:   r_cfg.rule_mode           <= i_cfg_data[0];
                    REG_BIRTH:       r_cfg.birth_level         <= i_cfg_data;
                    REG_STEP:        r_cfg.level_step          <= i_cfg_data;
                    REG_FLOOR:       r_cfg.floor_level         <= i_cfg_data;
                    REG_CEILING:     r_cfg.ceiling_level       <= i_cfg_data;
                    REG_NBR_THRESH:  r_cfg.neighbour_threshold <= i_cfg_data;
                    REG_LIVE_THRESH: r_cfg.alive_threshold     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // The finish state reloads the output register itself.
            if (r_out_v && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(CELL_TOTAL - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_rd_level <= '0;
                    unique case (r_item.cmd)
                        CMD_WRITE: begin
                            r_state <= S_FINISH;
                        end
                        CMD_READ: begin
                            r_state <= S_READ_WAIT;
                        end
                        CMD_GEN: begin
                            if (r_alive_total != '0) begin
                                r_gen_count <= r_gen_count + 1'b1;
                            end
                            r_k           <= '0;
                            r_issuing     <= 1'b1;
                            r_c           <= '0;
                            r_cx          <= '0;
                            r_cy          <= '0;
                            r_alive_acc   <= '0;
                            r_changed_acc <= '0;
                            r_state       <= S_GEN;
                        end
                        default: begin
                            r_gen_count <= '0;
                            r_state     <= S_FINISH;
                        end
                    endcase
                end
                S_READ_WAIT: begin
                    r_rd_level <= item_inside ? ram_rdata : '0;
                    r_state    <= S_FINISH;
                end
                S_GEN: begin
                    // Issue stage.
                    r_p1_v   <= r_issuing;
                    r_p1_inb <= (r_k < FEED_W'(CELL_TOTAL));
                    r_p1_ev  <= (r_k >= FEED_W'(GRID_SIDE + 1));
                    if (r_issuing) begin
                        r_k <= r_k + 1'b1;
                        if (r_k == FEED_W'(CELL_TOTAL + GRID_SIDE)) begin
                            r_issuing <= 1'b0;
                        end
                    end
                    // Shift stage.
                    r_p2_v  <= r_p1_v;
                    r_p2_ev <= r_p1_ev;
                    // Evaluate stage.
                    if (eval) begin
                        r_c <= r_c + 1'b1;
                        if (r_cx == COORD_W'(GRID_SIDE - 1)) begin
                            r_cx <= '0;
                            r_cy <= r_cy + 1'b1;
                        end else begin
                            r_cx <= r_cx + 1'b1;
                        end
                        r_alive_acc   <= r_alive_acc + COUNT_W'(next_level != '0);
                        r_changed_acc <= r_changed_acc + COUNT_W'(next_level != win.center);
                    end
                    if (eval_last) begin
                        r_alive_total   <= r_alive_acc + COUNT_W'(next_level != '0);
                        r_changed_total <= r_changed_acc + COUNT_W'(next_level != win.center);
                        r_state         <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_v <= 1'b1;
                        r_out   <= '{read_level: r_rd_level, alive_count: r_alive_total,
                                     change_count: r_changed_total,
                                     generation: r_gen_count};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The pipeline only runs during a generation.
    a_pipe_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_v || r_p2_v) |-> (r_state == S_GEN))
        else $error("generation pipeline active outside a generation");

    // A write-back never overtakes the read stream.
    a_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eval |-> (FEED_W'(r_c) < r_k))
        else $error("write-back address not behind read address");

    // A new result only comes from the finish state.
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !$past(r_out_v)) |-> ($past(r_state) == S_FINISH))
        else $error("result loaded outside finish state");

endmodule

`default_nettype wire

### tb/flg_checker.sv
// Checker of the fading life grid engine: watches the channels, predicts every result and compares.
`timescale 1ns / 100ps

module flg_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire flg_pkg::t_in_item  i_in_data,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire flg_pkg::t_out_item i_out_data,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data,
    output int                      o_fail_count,
    output int                      o_results_pending
);
    import flg_pkg::*;

    // Shadow copy of the engine state and its settings.
    t_cfg               settings;
    t_level             life_grid [CELL_TOTAL];
    logic [COUNT_W-1:0] alive_now;
    logic [COUNT_W-1:0] changed_now;
    logic [GEN_W-1:0]   gen_now;
    t_out_item          expected_results [$];
    int                 fails = 0;

    assign o_results_pending = expected_results.size();
    assign o_fail_count      = fails;

    function automatic int live_neighbours(int cx, int cy, t_level limit);
        int count;
        int nx;
        int ny;
        count = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                nx = cx + dx;
                ny = cy + dy;
                if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < GRID_SIDE
                        && ny < GRID_SIDE && life_grid[ny * GRID_SIDE + nx] > limit) begin
                    count++;
                end
            end
        end
        return count;
    endfunction

    function automatic t_level gained(t_level lvl);
        int v;
        v = int'(lvl) + int'(settings.level_step);
        if (v > int'(settings.ceiling_level)) begin
            v = settings.ceiling_level;
        end
        return t_level'(v);
    endfunction

    function automatic t_level faded(t_level lvl);
        int v;
        v = int'(lvl) - int'(settings.level_step);
        if (v < int'(settings.floor_level)) begin
            v = settings.floor_level;
        end
        return t_level'(v);
    endfunction

    // One generation over the whole grid, then the counts and the counter.
    task automatic advance_generation();
        t_level next_grid [CELL_TOTAL];
        t_level here;
        int     n;
        int     alive;
        int     changed;
        alive   = 0;
        changed = 0;
        for (int y = 0; y < GRID_SIDE; y++) begin
            for (int x = 0; x < GRID_SIDE; x++) begin
                here = life_grid[y * GRID_SIDE + x];
                if (settings.rule_mode) begin
                    n = live_neighbours(x, y, 8'd0);
                    if (here != 0) begin
                        next_grid[y * GRID_SIDE + x] = (n == 2 || n == 3) ? gained(here) : 8'd0;
                    end else begin
                        next_grid[y * GRID_SIDE + x] = (n == 3) ? settings.birth_level : 8'd0;
                    end
                end else begin
                    n = live_neighbours(x, y, settings.neighbour_threshold);
                    if (here > settings.alive_threshold) begin
                        next_grid[y * GRID_SIDE + x] = (n == 2 || n == 3) ? gained(here)
                                                                          : faded(here);
                    end else begin
                        next_grid[y * GRID_SIDE + x] = (n == 3) ? gained(here) : 8'd0;
                    end
                end
            end
        end
        if (alive_now != 0) begin
            gen_now = gen_now + 1'b1;
        end
        for (int i = 0; i < CELL_TOTAL; i++) begin
            if (next_grid[i] != 0) alive++;
            if (next_grid[i] != life_grid[i]) changed++;
            life_grid[i] = next_grid[i];
        end
        alive_now   = COUNT_W'(alive);
        changed_now = COUNT_W'(changed);
    endtask

    // Apply one command to the shadow state and return its result.
    task automatic predict_command(input t_in_item item, output t_out_item res);
        int addr;
        addr = int'(item.cell_y) * GRID_SIDE + int'(item.cell_x);
        res.read_level = '0;
        case (t_cmd'(item.cmd))
            CMD_WRITE: begin
                life_grid[addr] = item.cell_value;
            end
            CMD_READ: begin
                res.read_level = life_grid[addr];
            end
            CMD_GEN: begin
                advance_generation();
            end
            default: begin
                gen_now = '0;
            end
        endcase
        res.alive_count  = alive_now;
        res.change_count = changed_now;
        res.generation   = gen_now;
    endtask

    task automatic report(string field, int want, int got);
        $display("%0t: mismatch on %s, expected %0d, actual %0d", $realtime, field, want, got);
        fails++;
    endtask

    // Configuration transfers, input transfers and result transfers.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            settings = '{rule_mode: 1'b0, birth_level: 8'd100, level_step: 8'd1,
                         floor_level: 8'd10, ceiling_level: 8'd200,
                         neighbour_threshold: 8'd60, alive_threshold: 8'd40};
            for (int i = 0; i < CELL_TOTAL; i++) life_grid[i] = '0;
            alive_now   = '0;
            changed_now = '0;
            gen_now     = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_RULE_MODE:   settings.rule_mode = i_cfg_data[0];
                    REG_BIRTH:       settings.birth_level = i_cfg_data;
                    REG_STEP:        settings.level_step = i_cfg_data;
                    REG_FLOOR:       settings.floor_level = i_cfg_data;
                    REG_CEILING:     settings.ceiling_level = i_cfg_data;
                    REG_NBR_THRESH:  settings.neighbour_threshold = i_cfg_data;
                    REG_LIVE_THRESH: settings.alive_threshold = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_command(i_in_data, want);
                expected_results.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual %h",
                             $realtime, i_out_data);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.read_level !== want.read_level)
                        report("read_level", want.read_level, i_out_data.read_level);
                    if (i_out_data.alive_count !== want.alive_count)
                        report("alive_count", want.alive_count, i_out_data.alive_count);
                    if (i_out_data.change_count !== want.change_count)
                        report("change_count", want.change_count, i_out_data.change_count);
                    if (i_out_data.generation !== want.generation)
                        report("generation", want.generation, i_out_data.generation);
                end
            end
        end
    end

endmodule

### tb/tb_top.sv
// Testbench top of the fading life grid engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import flg_pkg::*;

    localparam logic [2:0] REG_UNUSED  = 3'd7;
    localparam int         STUCK_LIMIT = 30000;
    localparam int         IN_BITS     = $bits(t_in_item);

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    int        fail_count;
    int        results_pending;
    int        commands_sent = 0;
    int        results_taken = 0;
    int        stuck_cycles = 0;
    int        patch_x;
    int        patch_y;

    always #1 clk = ~clk;

    fading_life_grid_engine dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    flg_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_results_pending(results_pending)
    );

    // Transfer counting and the watchdog on cycles without progress.
    always @(posedge clk) begin
        if (out_valid && !out_stall) results_taken <= results_taken + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Result side: random stalls, one long hold-off, and a quiet window.
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 0;
        forever begin
            @(negedge clk);
            if (!held && results_taken >= 30) begin
                held      = 1;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (results_taken >= 80 && results_taken < 115) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 34);
            end
        end
    end

    // Offer one command and return at the edge that takes it; valid stays up.
    task automatic send_command(t_in_item item);
        if (commands_sent < 90 || commands_sent >= 120) begin
            while ($urandom_range(99) < 34) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        commands_sent++;
    endtask

    task automatic send_cell(t_cmd op, int x, int y, int lvl);
        t_in_item item;
        item.cmd        = op;
        item.cell_x     = 6'(x);
        item.cell_y     = 6'(y);
        item.cell_value = 8'(lvl);
        send_command(item);
    endtask

    task automatic write_register(logic [2:0] idx, logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every result has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_settings(int mode, int birth, int step, int floor_lvl, int ceil_lvl,
                                 int nbr_lim, int live_lim);
        write_register(REG_RULE_MODE, 8'(mode));
        write_register(REG_BIRTH, 8'(birth));
        write_register(REG_STEP, 8'(step));
        write_register(REG_FLOOR, 8'(floor_lvl));
        write_register(REG_CEILING, 8'(ceil_lvl));
        write_register(REG_NBR_THRESH, 8'(nbr_lim));
        write_register(REG_LIVE_THRESH, 8'(live_lim));
    endtask

    function automatic int pick_level();
        case ($urandom_range(5))
            0: return 0;
            1: return 255;
            2: return $urandom_range(30, 90);
            default: return $urandom_range(255);
        endcase
    endfunction

    // Mostly cell writes into a small patch followed by generations, plus noise.
    task automatic random_commands(int count);
        int roll;
        t_in_item item;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                send_cell(CMD_WRITE, patch_x + $urandom_range(5), patch_y + $urandom_range(5),
                          pick_level());
            end else if (roll < 70) begin
                send_cell(CMD_READ, patch_x + $urandom_range(6), patch_y + $urandom_range(6), 0);
            end else if (roll < 86) begin
                send_cell(CMD_GEN, 0, 0, 0);
            end else if (roll < 90) begin
                send_cell(CMD_CLR_GEN, $urandom_range(63), $urandom_range(63), 0);
            end else begin
                item = t_in_item'(IN_BITS'($urandom()));
                if (t_cmd'(item.cmd) == CMD_GEN && $urandom_range(1)) item.cmd = CMD_READ;
                send_command(item);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: grid corners, extreme levels, a blinker and every command.
        load_settings(0, 100, 1, 10, 200, 60, 40);
        write_register(REG_UNUSED, 8'hff);
        send_cell(CMD_WRITE, 0, 0, 255);
        send_cell(CMD_WRITE, 63, 63, 1);
        send_cell(CMD_WRITE, 63, 0, 0);
        send_cell(CMD_READ, 0, 0, 0);
        send_cell(CMD_READ, 63, 63, 0);
        send_cell(CMD_READ, 0, 63, 0);
        send_cell(CMD_WRITE, 10, 10, 200);
        send_cell(CMD_WRITE, 11, 10, 200);
        send_cell(CMD_WRITE, 12, 10, 200);
        send_cell(CMD_WRITE, 0, 1, 255);
        send_cell(CMD_WRITE, 1, 0, 255);
        send_cell(CMD_GEN, 0, 0, 0);
        send_cell(CMD_GEN, 0, 0, 0);
        send_cell(CMD_READ, 11, 11, 0);
        send_cell(CMD_READ, 1, 1, 0);
        send_cell(CMD_CLR_GEN, 0, 0, 0);
        send_cell(CMD_GEN, 0, 0, 0);
        send_cell(CMD_READ, 11, 10, 0);
        drain();

        // Classic rule with saturating extremes.
        load_settings(1, 255, 255, 0, 255, 0, 0);
        patch_x = $urandom_range(56);
        patch_y = $urandom_range(56);
        send_cell(CMD_WRITE, 5, 5, 7);
        send_cell(CMD_WRITE, 6, 5, 9);
        send_cell(CMD_WRITE, 7, 5, 3);
        send_cell(CMD_GEN, 0, 0, 0);
        random_commands(30);
        drain();

        // Fading rule with all levels and thresholds at zero and the full step, then a pause mid-phase.
        load_settings(0, 0, 255, 0, 0, 0, 0);
        patch_x = 0;
        patch_y = $urandom_range(56);
        random_commands(15);
        drain();
        random_commands(15);
        drain();

        // Fading rule with high floor and thresholds.
        load_settings(0, 17, 7, 255, 255, 255, 255);
        patch_x = 58;
        patch_y = 58;
        random_commands(20);
        drain();

        // Classic rule with zero birth level and no step, then a moderate fading setup.
        load_settings(1, 0, 0, 10, 200, 60, 40);
        patch_x = $urandom_range(56);
        patch_y = 0;
        random_commands(20);
        drain();
        load_settings(0, 100, 3, 20, 180, 50, 45);
        patch_x = $urandom_range(56);
        patch_y = $urandom_range(56);
        random_commands(30);
        drain();

        repeat (50) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/flg_pkg.sv
rtl/flg_ram.sv
rtl/flg_cell.sv
rtl/flg_rule.sv
rtl/fading_life_grid_engine.sv
tb/flg_checker.sv
tb/tb_top.sv
